// File: hw/rtl/indexed_min_heap_priority_queue_defines.svh
// Assertion macros shared by the checker.
`ifndef INDEXED_MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define INDEXED_MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define IMHPQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("imhpq assertion failed");

// Condition must never be seen outside reset.
`define IMHPQ_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("imhpq forbidden condition seen");

`endif

// File: hw/rtl/imhpq_pkg.sv
package imhpq_pkg;

  localparam int ElemW          = 6;
  localparam int KeyW           = 32;
  localparam int StatW          = 3;
  localparam int FillW          = 7;
  localparam int NumElems       = 64;
  localparam int MaxElementsDef = 64;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_CHANGE = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_PEEK   = 2'd3;

  localparam logic [StatW-1:0] ST_OK     = 3'd0;
  localparam logic [StatW-1:0] ST_EMPTY  = 3'd1;
  localparam logic [StatW-1:0] ST_FULL   = 3'd2;
  localparam logic [StatW-1:0] ST_ABSENT = 3'd3;
  localparam logic [StatW-1:0] ST_DUP    = 3'd4;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [ElemW-1:0] el;
  } heap_ent_t;

  typedef struct packed {
    logic [FillW-1:0] fill;
    logic [StatW-1:0] st;
    logic [KeyW-1:0]  key;
    logic [ElemW-1:0] el;
  } result_t;

endpackage

// File: hw/rtl/imhpq_heap_ram.sv
module imhpq_heap_ram #(
  parameter int Depth = imhpq_pkg::MaxElementsDef,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  imhpq_pkg::heap_ent_t wdata_i,
  input  logic [AddrW-1:0]     raddr0_i,
  input  logic [AddrW-1:0]     raddr1_i,
  output imhpq_pkg::heap_ent_t rdata0_o,
  output imhpq_pkg::heap_ent_t rdata1_o
);

  imhpq_pkg::heap_ent_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

// File: hw/rtl/imhpq_pos_ram.sv
module imhpq_pos_ram #(
  parameter int SlotW = 6
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [imhpq_pkg::ElemW-1:0] waddr_i,
  input  logic [SlotW-1:0]            wdata_i,
  input  logic [imhpq_pkg::ElemW-1:0] raddr_i,
  output logic [SlotW-1:0]            rdata_o
);

  logic [SlotW-1:0] mem [imhpq_pkg::NumElems];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hw/rtl/imhpq_ctrl.sv
module imhpq_ctrl #(
  parameter int MaxElements = imhpq_pkg::MaxElementsDef,
  parameter int SlotW       = $clog2(MaxElements),
  parameter int CountW      = $clog2(MaxElements + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  in_cmd_i,
  input  logic [imhpq_pkg::ElemW-1:0] in_el_i,
  input  logic [imhpq_pkg::KeyW-1:0]  in_key_i,
  output logic                        heap_we_o,
  output logic [SlotW-1:0]            heap_waddr_o,
  output imhpq_pkg::heap_ent_t        heap_wdata_o,
  output logic [SlotW-1:0]            heap_raddr0_o,
  output logic [SlotW-1:0]            heap_raddr1_o,
  input  imhpq_pkg::heap_ent_t        heap_rdata0_i,
  input  imhpq_pkg::heap_ent_t        heap_rdata1_i,
  output logic                        pos_we_o,
  output logic [imhpq_pkg::ElemW-1:0] pos_waddr_o,
  output logic [SlotW-1:0]            pos_wdata_o,
  output logic [imhpq_pkg::ElemW-1:0] pos_raddr_o,
  input  logic [SlotW-1:0]            pos_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output imhpq_pkg::result_t          out_o
);

  localparam int LW = SlotW + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_RDPOS = 4'd2;
  localparam logic [3:0] S_RDKEY = 4'd3;
  localparam logic [3:0] S_RDTOP = 4'd4;
  localparam logic [3:0] S_UPREQ = 4'd5;
  localparam logic [3:0] S_UPCMP = 4'd6;
  localparam logic [3:0] S_DNREQ = 4'd7;
  localparam logic [3:0] S_DNCMP = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]                  state_q, state_d;
  logic [1:0]                  cmd_q, cmd_d;
  logic [imhpq_pkg::ElemW-1:0] el_q, el_d;
  logic [imhpq_pkg::KeyW-1:0]  key_q, key_d;
  imhpq_pkg::heap_ent_t        mov_q, mov_d;
  logic [SlotW-1:0]            s_q, s_d;
  logic [CountW-1:0]           count_q, count_d;
  logic [imhpq_pkg::NumElems-1:0] present_q, present_d;
  logic                        place_q, place_d;
  logic [imhpq_pkg::ElemW-1:0] res_el_q, res_el_d;
  logic [imhpq_pkg::KeyW-1:0]  res_key_q, res_key_d;
  logic [imhpq_pkg::StatW-1:0] res_st_q, res_st_d;
  logic                        out_valid_q, out_valid_d;
  imhpq_pkg::result_t          out_q, out_d;

  logic          el_ok;
  logic [LW-1:0] lchild, rchild, cnt_ext, child;
  logic [SlotW-1:0] parent;
  logic          pick_l;
  imhpq_pkg::heap_ent_t child_ent;

  assign el_ok   = 32'(el_q) < 32'(MaxElements);
  assign cnt_ext = LW'(count_q);
  assign lchild  = {1'b0, s_q, 1'b1};
  assign rchild  = lchild + LW'(1);
  assign parent  = SlotW'((s_q - SlotW'(1)) >> 1);
  assign pick_l  = (rchild >= cnt_ext) ||
                   ($signed(heap_rdata0_i.key) < $signed(heap_rdata1_i.key));
  assign child     = pick_l ? lchild : rchild;
  assign child_ent = pick_l ? heap_rdata0_i : heap_rdata1_i;

  assign in_ready_o  = (state_q == S_IDLE);
  assign pos_raddr_o = el_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    el_d        = el_q;
    key_d       = key_q;
    mov_d       = mov_q;
    s_d         = s_q;
    count_d     = count_q;
    present_d   = present_q;
    place_d     = place_q;
    res_el_d    = res_el_q;
    res_key_d   = res_key_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    heap_we_o     = 1'b0;
    heap_waddr_o  = s_q;
    heap_wdata_o  = mov_q;
    heap_raddr0_o = '0;
    heap_raddr1_o = '0;
    pos_we_o      = 1'b0;
    pos_waddr_o   = mov_q.el;
    pos_wdata_o   = s_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_cmd_i;
          el_d    = in_el_i;
          key_d   = in_key_i;
          state_d = S_START;
        end
      end
      S_START: begin
        res_el_d      = el_q;
        res_key_d     = key_q;
        res_st_d      = imhpq_pkg::ST_OK;
        place_d       = 1'b0;
        heap_raddr0_o = '0;
        heap_raddr1_o = SlotW'(count_q - CountW'(1));
        unique case (cmd_q)
          imhpq_pkg::CMD_INSERT: begin
            if (!el_ok) begin
              res_st_d = imhpq_pkg::ST_ABSENT;
              state_d  = S_FIN;
            end else if (present_q[el_q]) begin
              res_st_d = imhpq_pkg::ST_DUP;
              state_d  = S_FIN;
            end else if (count_q == CountW'(MaxElements)) begin
              res_st_d = imhpq_pkg::ST_FULL;
              state_d  = S_FIN;
            end else begin
              present_d[el_q] = 1'b1;
              count_d         = count_q + CountW'(1);
              mov_d           = '{key: key_q, el: el_q};
              s_d             = SlotW'(count_q);
              place_d         = 1'b1;
              state_d         = S_UPREQ;
            end
          end
          imhpq_pkg::CMD_CHANGE: begin
            if (!el_ok || !present_q[el_q]) begin
              res_st_d = imhpq_pkg::ST_ABSENT;
              state_d  = S_FIN;
            end else begin
              state_d = S_RDPOS;
            end
          end
          default: begin
            if (count_q == '0) begin
              res_st_d  = imhpq_pkg::ST_EMPTY;
              res_el_d  = '0;
              res_key_d = '0;
              state_d   = S_FIN;
            end else begin
              state_d = S_RDTOP;
            end
          end
        endcase
      end
      S_RDPOS: begin
        heap_raddr0_o = pos_rdata_i;
        s_d           = pos_rdata_i;
        state_d       = S_RDKEY;
      end
      S_RDKEY: begin
        mov_d   = '{key: key_q, el: el_q};
        place_d = 1'b1;
        // grown key sinks, otherwise rise
        if ($signed(heap_rdata0_i.key) < $signed(key_q)) begin
          state_d = S_DNREQ;
        end else begin
          state_d = S_UPREQ;
        end
      end
      S_RDTOP: begin
        res_el_d  = heap_rdata0_i.el;
        res_key_d = heap_rdata0_i.key;
        if (cmd_q == imhpq_pkg::CMD_PEEK) begin
          state_d = S_FIN;
        end else begin
          present_d[heap_rdata0_i.el] = 1'b0;
          count_d = count_q - CountW'(1);
          mov_d   = heap_rdata1_i;
          s_d     = '0;
          place_d = 1'b1;
          state_d = S_DNREQ;
        end
      end
      S_UPREQ: begin
        heap_raddr0_o = parent;
        state_d       = (s_q == '0) ? S_FIN : S_UPCMP;
      end
      S_UPCMP: begin
        if ($signed(mov_q.key) < $signed(heap_rdata0_i.key)) begin
          // pull the parent down into the hole
          heap_we_o    = 1'b1;
          heap_wdata_o = heap_rdata0_i;
          pos_we_o     = 1'b1;
          pos_waddr_o  = heap_rdata0_i.el;
          s_d          = parent;
          state_d      = S_UPREQ;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DNREQ: begin
        heap_raddr0_o = SlotW'(lchild);
        heap_raddr1_o = SlotW'(rchild);
        state_d       = (lchild >= cnt_ext) ? S_FIN : S_DNCMP;
      end
      S_DNCMP: begin
        if ($signed(child_ent.key) < $signed(mov_q.key)) begin
          heap_we_o    = 1'b1;
          heap_wdata_o = child_ent;
          pos_we_o     = 1'b1;
          pos_waddr_o  = child_ent.el;
          s_d          = SlotW'(child);
          state_d      = S_DNREQ;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          heap_we_o   = place_q;
          pos_we_o    = place_q;
          out_valid_d = 1'b1;
          out_d       = '{fill: imhpq_pkg::FillW'(count_q), st: res_st_q,
                          key: res_key_q, el: res_el_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      present_q   <= '0;
      place_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      present_q   <= present_d;
      place_q     <= place_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    el_q      <= el_d;
    key_q     <= key_d;
    mov_q     <= mov_d;
    s_q       <= s_d;
    res_el_q  <= res_el_d;
    res_key_q <= res_key_d;
    res_st_q  <= res_st_d;
    out_q     <= out_d;
  end

endmodule

// File: hw/rtl/indexed_min_heap_priority_queue.sv
// Channel   | Direction | tdata (low bit up)                 | tuser
// s_axis    | in        | element_id[5:0], key_value[37:6]   | cmd[1:0]
// m_axis    | out       | out_element, out_key, fill_count   | status[2:0]
//
// One item at a time: setup and one read request, then per heap level walked a compare
// and write back and the next read, then a finish step and a return to idle.
// Reset clears the count and the per-element present bits; no memory sweep.
// A result waits in the output register while the next item is taken.
module indexed_min_heap_priority_queue #(
  parameter int MAX_ELEMENTS = imhpq_pkg::MaxElementsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // element_id[5:0], key_value[37:6], zero pad
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_element[5:0], out_key[37:6], fill_count[44:38]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);

  localparam int SlotW  = $clog2(MAX_ELEMENTS);
  localparam int CountW = $clog2(MAX_ELEMENTS + 1);

  logic                        heap_we;
  logic [SlotW-1:0]            heap_waddr, heap_raddr0, heap_raddr1;
  imhpq_pkg::heap_ent_t        heap_wdata, heap_rdata0, heap_rdata1;
  logic                        pos_we;
  logic [imhpq_pkg::ElemW-1:0] pos_waddr, pos_raddr;
  logic [SlotW-1:0]            pos_wdata, pos_rdata;
  imhpq_pkg::result_t          res;

  imhpq_ctrl #(
    .MaxElements(MAX_ELEMENTS),
    .SlotW      (SlotW),
    .CountW     (CountW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_el_i      (s_axis_tdata[5:0]),
    .in_key_i     (s_axis_tdata[37:6]),
    .heap_we_o    (heap_we),
    .heap_waddr_o (heap_waddr),
    .heap_wdata_o (heap_wdata),
    .heap_raddr0_o(heap_raddr0),
    .heap_raddr1_o(heap_raddr1),
    .heap_rdata0_i(heap_rdata0),
    .heap_rdata1_i(heap_rdata1),
    .pos_we_o     (pos_we),
    .pos_waddr_o  (pos_waddr),
    .pos_wdata_o  (pos_wdata),
    .pos_raddr_o  (pos_raddr),
    .pos_rdata_i  (pos_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  imhpq_heap_ram #(
    .Depth(MAX_ELEMENTS),
    .AddrW(SlotW)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .raddr0_i(heap_raddr0),
    .raddr1_i(heap_raddr1),
    .rdata0_o(heap_rdata0),
    .rdata1_o(heap_rdata1)
  );

  imhpq_pos_ram #(
    .SlotW(SlotW)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pos_we),
    .waddr_i(pos_waddr),
    .wdata_i(pos_wdata),
    .raddr_i(pos_raddr),
    .rdata_o(pos_rdata)
  );

  assign m_axis_tdata = {3'b000, res.fill, res.key, res.el};
  assign m_axis_tuser = res.st;

endmodule

// File: hw/rtl/imhpq_checker.sv
`include "indexed_min_heap_priority_queue_defines.svh"

module imhpq_checker #(
  parameter int MAX_ELEMENTS = imhpq_pkg::MaxElementsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // hold a result until it is taken
  `IMHPQ_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  // one item in work at a time
  `IMHPQ_ASSERT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `IMHPQ_NEVER(a_fill_range, clk_i, rst_ni, m_axis_tvalid && (32'(m_axis_tdata[44:38]) > 32'(MAX_ELEMENTS)))
  `IMHPQ_NEVER(a_empty_fill, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == imhpq_pkg::ST_EMPTY) && (m_axis_tdata[44:38] != 7'd0))

endmodule

bind indexed_min_heap_priority_queue imhpq_checker #(
  .MAX_ELEMENTS(MAX_ELEMENTS)
) u_imhpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// File: bench/indexed_min_heap_priority_queue_tb.sv
`timescale 1ns / 100ps

module indexed_min_heap_priority_queue_tb;

  localparam int QueueCap   = 64;
  localparam int RandItems  = 1464;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic [imhpq_pkg::FillW-1:0] fill;
    logic [imhpq_pkg::StatW-1:0] st;
    logic [imhpq_pkg::KeyW-1:0]  key;
    logic [imhpq_pkg::ElemW-1:0] el;
  } heap_answer_t;

  typedef struct {
    logic [1:0]                  cmd;
    logic [imhpq_pkg::ElemW-1:0] el;
    logic [imhpq_pkg::KeyW-1:0]  key;
    bit                          typed;
    heap_answer_t                ans;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  indexed_min_heap_priority_queue DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #1 clk_i = ~clk_i;

  // shadow heap
  logic [imhpq_pkg::ElemW-1:0] slot_el [QueueCap];
  int                          el_slot [QueueCap];
  bit                          el_held [QueueCap];
  logic [imhpq_pkg::KeyW-1:0]  el_key  [QueueCap];
  int                          held_n;

  heap_answer_t pending_answers[$];
  int  errors, answers_seen, stall_cycles;
  int  st_hits [8];
  bit  stim_done;

  function automatic bit key_lt(logic [imhpq_pkg::KeyW-1:0] a, logic [imhpq_pkg::KeyW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic bit slot_lt(int s, int t);
    return key_lt(el_key[slot_el[s]], el_key[slot_el[t]]);
  endfunction

  function automatic void swap_slots(int s, int t);
    logic [imhpq_pkg::ElemW-1:0] es, et;
    es = slot_el[s];
    et = slot_el[t];
    slot_el[s] = et;
    slot_el[t] = es;
    el_slot[et] = s;
    el_slot[es] = t;
  endfunction

  function automatic void bubble_up(int s);
    int p;
    while (s > 0) begin
      p = (s - 1) / 2;
      if (!slot_lt(s, p)) break;
      swap_slots(s, p);
      s = p;
    end
  endfunction

  function automatic void bubble_down(int s);
    int l, c;
    forever begin
      l = 2 * s + 1;
      if (l >= held_n) break;
      c = (l + 1 >= held_n || slot_lt(l, l + 1)) ? l : l + 1;
      if (!slot_lt(c, s)) break;
      swap_slots(s, c);
      s = c;
    end
  endfunction

  function automatic heap_answer_t heap_apply(logic [1:0] cmd,
                                              logic [imhpq_pkg::ElemW-1:0] el,
                                              logic [imhpq_pkg::KeyW-1:0] key);
    heap_answer_t a;
    logic [imhpq_pkg::KeyW-1:0]  old;
    logic [imhpq_pkg::ElemW-1:0] top;
    a.el = el;
    a.key = key;
    a.st = imhpq_pkg::ST_OK;
    case (cmd)
      imhpq_pkg::CMD_INSERT: begin
        if (el_held[el]) a.st = imhpq_pkg::ST_DUP;
        else if (held_n >= QueueCap) a.st = imhpq_pkg::ST_FULL;
        else begin
          el_key[el] = key;
          slot_el[held_n] = el;
          el_slot[el] = held_n;
          el_held[el] = 1'b1;
          held_n++;
          bubble_up(held_n - 1);
        end
      end
      imhpq_pkg::CMD_CHANGE: begin
        if (!el_held[el]) a.st = imhpq_pkg::ST_ABSENT;
        else begin
          old = el_key[el];
          el_key[el] = key;
          if (key_lt(old, key)) bubble_down(el_slot[el]);
          else bubble_up(el_slot[el]);
        end
      end
      default: begin
        if (held_n == 0) begin
          a.st = imhpq_pkg::ST_EMPTY;
          a.el = '0;
          a.key = '0;
        end else begin
          top = slot_el[0];
          a.el = top;
          a.key = el_key[top];
          if (cmd == imhpq_pkg::CMD_REMOVE) begin
            swap_slots(0, held_n - 1);
            held_n--;
            bubble_down(0);
            el_held[top] = 1'b0;
          end
        end
      end
    endcase
    a.fill = held_n[imhpq_pkg::FillW-1:0];
    return a;
  endfunction

  // mostly short gaps, now and then a long one
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic send_item(logic [1:0] cmd, logic [imhpq_pkg::ElemW-1:0] el,
                           logic [imhpq_pkg::KeyW-1:0] key,
                           bit typed, heap_answer_t typed_ans);
    heap_answer_t a;
    a = heap_apply(cmd, el, key);
    if (typed && a !== typed_ans)
      $display("%0t table row disagrees with predictor: table %h predictor %h",
               $time, typed_ans, a);
    pending_answers.push_back(typed ? typed_ans : a);
    s_axis_tuser <= cmd;
    s_axis_tdata <= {2'b0, key, el};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    // keep the drop and the next raise on separate edges
    @(negedge clk_i);
  endtask

  function automatic logic [imhpq_pkg::KeyW-1:0] rand_key();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 7) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t row(logic [1:0] cmd, logic [imhpq_pkg::ElemW-1:0] el,
                                    logic [imhpq_pkg::KeyW-1:0] key, bit typed = 0,
                                    logic [imhpq_pkg::ElemW-1:0] ael = 0,
                                    logic [imhpq_pkg::KeyW-1:0] akey = 0,
                                    logic [imhpq_pkg::StatW-1:0] ast = 0,
                                    logic [imhpq_pkg::FillW-1:0] afill = 0);
    stim_row_t r;
    r.cmd = cmd;
    r.el = el;
    r.key = key;
    r.typed = typed;
    r.ans = '{fill: afill, st: ast, key: akey, el: ael};
    return r;
  endfunction

  stim_row_t directed[$];

  initial begin
    logic [1:0] cmd;
    logic [imhpq_pkg::ElemW-1:0] el;
    int k;
    held_n = 0;
    foreach (el_held[i]) begin
      el_held[i] = 1'b0;
      el_key[i] = '0;
    end
    directed = '{
      row(imhpq_pkg::CMD_REMOVE, 6'd5, 32'h1234, 1, 6'd0, 32'h0, imhpq_pkg::ST_EMPTY, 7'd0),
      row(imhpq_pkg::CMD_PEEK, 6'd9, 32'h1, 1, 6'd0, 32'h0, imhpq_pkg::ST_EMPTY, 7'd0),
      row(imhpq_pkg::CMD_CHANGE, 6'd7, 32'h5, 1, 6'd7, 32'h5, imhpq_pkg::ST_ABSENT, 7'd0),
      row(imhpq_pkg::CMD_INSERT, 6'd63, 32'h7FFF_FFFF, 1, 6'd63, 32'h7FFF_FFFF,
          imhpq_pkg::ST_OK, 7'd1),
      row(imhpq_pkg::CMD_INSERT, 6'd0, 32'h8000_0000, 1, 6'd0, 32'h8000_0000,
          imhpq_pkg::ST_OK, 7'd2),
      row(imhpq_pkg::CMD_INSERT, 6'd0, 32'h0, 1, 6'd0, 32'h0, imhpq_pkg::ST_DUP, 7'd2),
      row(imhpq_pkg::CMD_PEEK, 6'd0, 32'h0, 1, 6'd0, 32'h8000_0000, imhpq_pkg::ST_OK, 7'd2),
      row(imhpq_pkg::CMD_INSERT, 6'd21, 32'h0001_0000),
      row(imhpq_pkg::CMD_INSERT, 6'd42, 32'h0001_0000),
      row(imhpq_pkg::CMD_INSERT, 6'd10, 32'hFFFF_0000),
      row(imhpq_pkg::CMD_CHANGE, 6'd0, 32'h0002_0000),
      row(imhpq_pkg::CMD_CHANGE, 6'd42, 32'h0001_0000),
      row(imhpq_pkg::CMD_CHANGE, 6'd63, 32'h8000_0001),
      row(imhpq_pkg::CMD_PEEK, 6'd0, 32'h0),
      row(imhpq_pkg::CMD_REMOVE, 6'd0, 32'h0),
      row(imhpq_pkg::CMD_REMOVE, 6'd0, 32'h0),
      row(imhpq_pkg::CMD_REMOVE, 6'd0, 32'h0),
      row(imhpq_pkg::CMD_REMOVE, 6'd0, 32'h0),
      row(imhpq_pkg::CMD_REMOVE, 6'd0, 32'h0),
      row(imhpq_pkg::CMD_REMOVE, 6'd0, 32'h0),
      row(imhpq_pkg::CMD_REMOVE, 6'd0, 32'h0, 1, 6'd0, 32'h0, imhpq_pkg::ST_EMPTY, 7'd0)
    };
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) begin
      send_item(directed[i].cmd, directed[i].el, directed[i].key,
                directed[i].typed, directed[i].ans);
      idle_gap();
    end
    // fill to the brim, then probe with an id already held
    for (int i = 0; i < QueueCap; i++) begin
      send_item(imhpq_pkg::CMD_INSERT, i[imhpq_pkg::ElemW-1:0], rand_key(), 0, '0);
      idle_gap();
    end
    send_item(imhpq_pkg::CMD_INSERT, 6'd3, 32'h0, 0, '0);
    // let all expected results come back before going on
    while (pending_answers.size() != 0) @(negedge clk_i);
    for (int i = 0; i < RandItems; i++) begin
      k = $urandom_range(0, 99);
      // bias toward growing while small and shrinking while large
      if (k < (held_n < 48 ? 45 : 25)) cmd = imhpq_pkg::CMD_INSERT;
      else if (k < 70) cmd = imhpq_pkg::CMD_CHANGE;
      else if (k < 92) cmd = imhpq_pkg::CMD_REMOVE;
      else cmd = imhpq_pkg::CMD_PEEK;
      el = imhpq_pkg::ElemW'($urandom);
      if (cmd == imhpq_pkg::CMD_CHANGE && held_n > 0 && $urandom_range(0, 4) != 0)
        el = slot_el[$urandom_range(0, held_n - 1)];
      if (cmd == imhpq_pkg::CMD_CHANGE && held_n > 0 && $urandom_range(0, 3) == 0)
        send_item(cmd, el, el_key[el] + $urandom_range(0, 2) - 1, 0, '0);
      else
        send_item(cmd, el, rand_key(), 0, '0);
      idle_gap();
    end
    stim_done = 1'b1;
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 9) < 7 || answers_seen % 300 < 40) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 15) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
  end

  always @(posedge clk_i) begin
    heap_answer_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[44:38], m_axis_tuser, m_axis_tdata[37:0]};
        answers_seen <= answers_seen + 1;
        if (pending_answers.size() == 0) begin
          errors <= errors + 1;
          $display("%0t unexpected result: expected none, actual %h", $time, got);
        end else begin
          want = pending_answers.pop_front();
          st_hits[got.st] <= st_hits[got.st] + 1;
          if (got.el !== want.el || got.key !== want.key ||
              got.st !== want.st || got.fill !== want.fill) begin
            errors <= errors + 1;
            $display({"%0t mismatch: expected el %0d key %h st %0d fill %0d, ",
                      "actual el %0d key %h st %0d fill %0d"},
                     $time, want.el, want.key, want.st, want.fill,
                     got.el, got.key, got.st, got.fill);
          end
        end
      end
    end
  end

  initial begin
    errors = 0;
    answers_seen = 0;
    stall_cycles = 0;
    stim_done = 0;
    foreach (st_hits[i]) st_hits[i] = 0;
    forever begin
      @(negedge clk_i);
      if (stall_cycles >= StallLimit) begin
        $display("%0t timeout, %0d results still expected", $time, pending_answers.size());
        $display("RESULT: ERROR");
        $finish;
      end
      if (stim_done && pending_answers.size() == 0) begin
        repeat (40) @(negedge clk_i);
        $display("Checked %0d heap commands: ok %0d, empty %0d, full %0d, absent %0d, dup %0d",
                 answers_seen, st_hits[imhpq_pkg::ST_OK], st_hits[imhpq_pkg::ST_EMPTY],
                 st_hits[imhpq_pkg::ST_FULL], st_hits[imhpq_pkg::ST_ABSENT],
                 st_hits[imhpq_pkg::ST_DUP]);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/imhpq_pkg.sv
hw/rtl/imhpq_heap_ram.sv
hw/rtl/imhpq_pos_ram.sv
hw/rtl/imhpq_ctrl.sv
hw/rtl/indexed_min_heap_priority_queue.sv
hw/rtl/imhpq_checker.sv
bench/indexed_min_heap_priority_queue_tb.sv
